### design/svpwm_pkg.sv
package svpwm_pkg;
  localparam int VOLT_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int DUTY_FRAC_BITS_DEF = 15;
  localparam int DUTY_W = 16;
  localparam int SECTOR_W = 3;
  localparam logic [17:0] SQRT3_Q16 = 18'd113512;
  typedef logic [SECTOR_W-1:0] sector_t;
  localparam sector_t SEC_I = 3'd0;
  localparam sector_t SEC_II = 3'd1;
  localparam sector_t SEC_III = 3'd2;
  localparam sector_t SEC_IV = 3'd3;
  localparam sector_t SEC_V = 3'd4;
  localparam sector_t SEC_VI = 3'd5;
endpackage

### design/svpwm_div.sv
module svpwm_div #(
  parameter int NW = 40,
  parameter int QW = 16,
  parameter int FB = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  logic [QW-1:0] extra_in,
  output logic          out_vld,
  output logic [FB:0]   quo,
  output logic [QW-1:0] extra_out
);
  // one quotient bit per stage, restoring division of num*2^FB by den (num <= den)
  localparam int ST = FB + 1;
  logic [NW:0]   rem_r   [ST];
  logic [NW-1:0] den_r   [ST];
  logic [FB:0]   q_r     [ST];
  logic [QW-1:0] x_r     [ST];
  logic          v_r     [ST];
  logic [NW:0]   rem_nxt [ST];
  logic          ge      [ST];

  always_comb begin
    logic [NW:0] rin;
    rin = {1'b0, num};
    ge[0] = rin >= {1'b0, den};
    rem_nxt[0] = ge[0] ? (rin - {1'b0, den}) : rin;
    for (int i = 1; i < ST; i++) begin
      rin = {rem_r[i-1][NW-1:0], 1'b0};
      ge[i] = rin >= {1'b0, den_r[i-1]};
      rem_nxt[i] = ge[i] ? (rin - {1'b0, den_r[i-1]}) : rin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_vld;
      for (int i = 1; i < ST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= rem_nxt[0];
      den_r[0] <= den;
      q_r[0]   <= {{FB{1'b0}}, ge[0]};
      x_r[0]   <= extra_in;
      for (int i = 1; i < ST; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_r[i-1];
        q_r[i]   <= {q_r[i-1][FB-1:0], ge[i]};
        x_r[i]   <= x_r[i-1];
      end
    end
  end

  assign out_vld   = v_r[ST-1];
  assign quo       = q_r[ST-1];
  assign extra_out = x_r[ST-1];
endmodule

### design/svpwm_duty_calculator_core.sv
// space vector pwm with inverse park: one request per cycle unless the output
// stalls, fully pipelined. stages: products, rotate, constant multiplies,
// sector and numerator forms, select, overmod, FB+1 divider stages in a separate
// lane for each active time, duty assembly into the output register. the whole
// pipe advances whenever the output register is empty or being drained, so a
// stall holds every stage in place.
module svpwm_duty_calculator_core #(
  parameter int VOLT_BITS      = svpwm_pkg::VOLT_BITS_DEF,
  parameter int ANGLE_BITS     = svpwm_pkg::ANGLE_BITS_DEF,
  parameter int DUTY_FRAC_BITS = svpwm_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // volt_d, volt_q, bus_volt, sine_angle, cosine_angle (lowest first)
  input  logic [((3*VOLT_BITS+2*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // duty_a, duty_b, duty_c, sector, over_modulated, bus_fault (lowest first)
  output logic [55:0] out_tdata
);
  import svpwm_pkg::*;
  localparam int VB = VOLT_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int FB = DUTY_FRAC_BITS;
  localparam int SH = (VB + AB > 32) ? VB + AB - 32 : 0;
  localparam int PW = VB + AB + 1;        // exact product sum
  localparam int RW = PW - SH;            // reduced alpha/beta
  localparam int NW = RW + 21;            // signed numerator width
  localparam int DW = NW + 1;             // unsigned divider width
  localparam int BS = AB + 16 - SH;

  logic adv;
  logic out_vld_r;
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // stage 1: products
  logic signed [VB-1:0] vd, vq;
  logic signed [AB-1:0] sn, cs;
  logic [VB-1:0] bus;
  assign vd  = $signed(in_tdata[VB-1:0]);
  assign vq  = $signed(in_tdata[2*VB-1:VB]);
  assign bus = in_tdata[3*VB-1:2*VB];
  assign sn  = $signed(in_tdata[3*VB+AB-1:3*VB]);
  assign cs  = $signed(in_tdata[3*VB+2*AB-1:3*VB+AB]);

  logic v1_r;
  logic signed [VB+AB-1:0] p_dc_r, p_qs_r, p_ds_r, p_qc_r;
  logic [VB-1:0] bus1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_dc_r <= vd * cs;
      p_qs_r <= vq * sn;
      p_ds_r <= vd * sn;
      p_qc_r <= vq * cs;
      bus1_r <= bus;
    end
  end

  // stage 2: alpha, beta (floor shift)
  logic signed [PW-1:0] al_full, be_full;
  assign al_full = PW'(p_dc_r) - PW'(p_qs_r);
  assign be_full = PW'(p_ds_r) + PW'(p_qc_r);
  logic v2_r;
  logic signed [RW-1:0] al2_r, be2_r;
  logic [VB-1:0] bus2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      al2_r  <= RW'(al_full >>> SH);
      be2_r  <= RW'(be_full >>> SH);
      bus2_r <= bus1_r;
    end
  end

  // stage 3: constant multiplies
  logic v3_r;
  logic signed [NW-1:0] s3a_r, s3b_r, a3_r, bq_r;
  logic signed [RW-1:0] al3_r, be3_r;
  logic [VB-1:0] bus3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3a_r  <= NW'(al2_r) * $signed({1'b0, SQRT3_Q16});
      s3b_r  <= NW'(be2_r) * $signed({1'b0, SQRT3_Q16});
      a3_r   <= NW'(al2_r) * NW'(196608);
      bq_r   <= NW'(be2_r) <<< 16;
      al3_r  <= al2_r;
      be3_r  <= be2_r;
      bus3_r <= bus2_r;
    end
  end

  // stage 4: sector and x/y/z
  logic signed [NW-1:0] abs3a, x2c, y2c, z2c;
  sector_t sec_c;
  assign abs3a = s3a_r[NW-1] ? -s3a_r : s3a_r;
  assign x2c = s3b_r <<< 1;
  assign y2c = a3_r + s3b_r;
  assign z2c = s3b_r - a3_r;
  always_comb begin
    if (!be3_r[RW-1])
      sec_c = (abs3a < bq_r) ? SEC_II : ((al3_r > 0) ? SEC_I : SEC_III);
    else
      sec_c = (abs3a < -bq_r) ? SEC_V : ((al3_r > 0) ? SEC_VI : SEC_IV);
  end
  logic v4_r;
  logic signed [NW-1:0] x2_r, y2_r, z2_r;
  sector_t sec4_r;
  logic [VB-1:0] bus4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r <= x2c; y2_r <= y2c; z2_r <= z2c;
      sec4_r <= sec_c; bus4_r <= bus3_r;
    end
  end

  // stage 5: select numerators, clamp negative
  logic signed [NW-1:0] n1c, n2c;
  always_comb begin
    unique case (sec4_r)
      SEC_I:   begin n1c = -z2_r; n2c = x2_r;  end
      SEC_II:  begin n1c = z2_r;  n2c = y2_r;  end
      SEC_III: begin n1c = x2_r;  n2c = -y2_r; end
      SEC_IV:  begin n1c = -x2_r; n2c = z2_r;  end
      SEC_V:   begin n1c = -y2_r; n2c = -z2_r; end
      default: begin n1c = y2_r;  n2c = -x2_r; end
    endcase
  end
  logic v5_r;
  logic [DW-1:0] n1_r, n2_r, bden_r;
  sector_t sec5_r;
  logic fault5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r <= n1c[NW-1] ? '0 : DW'(unsigned'(n1c));
      n2_r <= n2c[NW-1] ? '0 : DW'(unsigned'(n2c));
      bden_r <= DW'(bus4_r) << BS;
      sec5_r <= sec4_r;
      fault5_r <= (bus4_r == '0);
    end
  end

  // stage 6: overmodulation
  logic [DW-1:0] nsum;
  assign nsum = n1_r + n2_r;
  logic v6_r;
  logic [DW-1:0] n16_r, n26_r, den6_r;
  logic [5:0] tag6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      n16_r <= n1_r;
      n26_r <= n2_r;
      den6_r <= (fault5_r || nsum <= bden_r) ? (fault5_r ? DW'(1) : bden_r) : nsum;
      tag6_r <= {fault5_r, !fault5_r && (nsum > bden_r), 1'b0, sec5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  // divider lanes
  logic dv1, dv2;
  logic [FB:0] t1, t2;
  logic [5:0] tagd, tagd2;
  svpwm_div #(.NW(DW), .QW(6), .FB(FB)) u_div1 (
    .clk, .rst_n, .adv, .in_vld(v6_r), .num(n16_r), .den(den6_r),
    .extra_in(tag6_r), .out_vld(dv1), .quo(t1), .extra_out(tagd));
  svpwm_div #(.NW(DW), .QW(6), .FB(FB)) u_div2 (
    .clk, .rst_n, .adv, .in_vld(v6_r), .num(n26_r), .den(den6_r),
    .extra_in(tag6_r), .out_vld(dv2), .quo(t2), .extra_out(tagd2));

  // duty assembly
  logic [FB+1:0] one_q, t12, t0, h, da, db, dc;
  sector_t secd;
  assign secd  = tagd[SECTOR_W-1:0];
  assign one_q = (FB+2)'(1) << FB;
  assign t12   = (FB+2)'(t1) + (FB+2)'(t2);
  assign t0    = one_q - t12;
  assign h     = t0 >> 1;
  always_comb begin
    unique case (secd)
      SEC_I:   begin da = t12 + h; db = (FB+2)'(t2) + h; dc = h; end
      SEC_II:  begin da = (FB+2)'(t2) + h; db = t12 + h; dc = h; end
      SEC_III: begin da = h; db = t12 + h; dc = (FB+2)'(t2) + h; end
      SEC_IV:  begin da = h; db = (FB+2)'(t2) + h; dc = t12 + h; end
      SEC_V:   begin da = (FB+2)'(t2) + h; db = h; dc = t12 + h; end
      default: begin da = t12 + h; db = h; dc = (FB+2)'(t2) + h; end
    endcase
  end

  logic [DUTY_W-1:0] da_r, db_r, dc_r;
  sector_t sec_r;
  logic over_r, fault_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      da_r <= tagd[5] ? '0 : DUTY_W'(da);
      db_r <= tagd[5] ? '0 : DUTY_W'(db);
      dc_r <= tagd[5] ? '0 : DUTY_W'(dc);
      sec_r <= secd;
      over_r <= tagd[4];
      fault_r <= tagd[5];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {3'b000, fault_r, over_r, sec_r, dc_r, db_r, da_r};

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    dv1 == dv2 && (!dv1 || tagd == tagd2)) else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[52] |-> out_tdata[47:0] == '0 && !out_tdata[51])
    else $error("bus fault with nonzero duty");
  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[50:48] <= SEC_VI) else $error("bad sector");
endmodule

### test/svpwm_checker.sv
module svpwm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import svpwm_pkg::*;

  typedef struct packed {
    logic             fault;
    logic             over;
    sector_t          sec;
    logic [15:0]      dc;
    logic [15:0]      db;
    logic [15:0]      da;
  } duty_set_t;

  duty_set_t duty_queue[$];

  // restoring division, num*2^15/den
  function automatic longint unsigned frac_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r = r - den;
    end
    for (int i = 0; i < 15; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        q = q | 1;
        r = r - den;
      end
    end
    return q;
  endfunction

  function automatic duty_set_t calc_duties(logic [79:0] d);
    longint vd, vq, sn, cs, al, be, s3a, abs3a, bq, x2, y2, z2, n1, n2;
    longint unsigned bus, den, t1, t2, t0, h, da, db, dc;
    sector_t sec;
    duty_set_t r;
    vd = longint'($signed(d[15:0]));
    vq = longint'($signed(d[31:16]));
    bus = longint'(d[47:32]);
    sn = longint'($signed(d[63:48]));
    cs = longint'($signed(d[79:64]));
    al = vd * cs - vq * sn;
    be = vd * sn + vq * cs;
    s3a = 113512 * al;
    abs3a = (s3a < 0) ? -s3a : s3a;
    bq = be * 65536;
    if (be >= 0) sec = (abs3a < bq) ? SEC_II : ((al > 0) ? SEC_I : SEC_III);
    else sec = (abs3a < -bq) ? SEC_V : ((al > 0) ? SEC_VI : SEC_IV);
    x2 = 2 * 113512 * be;
    y2 = 3 * 65536 * al + 113512 * be;
    z2 = -3 * 65536 * al + 113512 * be;
    case (sec)
      SEC_I: begin n1 = -z2; n2 = x2; end
      SEC_II: begin n1 = z2; n2 = y2; end
      SEC_III: begin n1 = x2; n2 = -y2; end
      SEC_IV: begin n1 = -x2; n2 = z2; end
      SEC_V: begin n1 = -y2; n2 = -z2; end
      default: begin n1 = y2; n2 = -x2; end
    endcase
    if (n1 < 0) n1 = 0;
    if (n2 < 0) n2 = 0;
    da = 0;
    db = 0;
    dc = 0;
    r.over = 1'b0;
    r.fault = 1'b0;
    if (bus == 0) begin
      r.fault = 1'b1;
    end else begin
      den = bus << 32;
      if (longint'(n1) + longint'(n2) > den) begin
        r.over = 1'b1;
        den = n1 + n2;
      end
      t1 = frac_quot(n1, den);
      t2 = frac_quot(n2, den);
      t0 = 32768 - t1 - t2;
      h = t0 >> 1;
      case (sec)
        SEC_I: begin da = t1 + t2 + h; db = t2 + h; dc = h; end
        SEC_II: begin da = t2 + h; db = t1 + t2 + h; dc = h; end
        SEC_III: begin da = h; db = t1 + t2 + h; dc = t2 + h; end
        SEC_IV: begin da = h; db = t2 + h; dc = t1 + t2 + h; end
        SEC_V: begin da = t2 + h; db = h; dc = t1 + t2 + h; end
        default: begin da = t1 + t2 + h; db = h; dc = t2 + h; end
      endcase
    end
    r.da = da[15:0];
    r.db = db[15:0];
    r.dc = dc[15:0];
    r.sec = sec;
    return r;
  endfunction

  assign pending_count = duty_queue.size();

  always @(posedge clk) begin
    duty_set_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready) duty_queue.push_back(calc_duties(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[52:0];
        result_count <= result_count + 1;
        if (duty_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = duty_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch: exp a=%0d b=%0d c=%0d sec=%0d ov=%0b fl=%0b",
                        " got a=%0d b=%0d c=%0d sec=%0d ov=%0b fl=%0b"},
                       want.da, want.db, want.dc, want.sec, want.over, want.fault,
                       got.da, got.db, got.dc, got.sec, got.over, got.fault);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 23;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  int          fail_count, pending_count, result_count;
  longint      cycle_count = 0;
  int          sent_count = 0;
  bit          out_hold = 1'b0;
  bit          no_gaps = 1'b0;

  always #1 clk = ~clk;

  svpwm_duty_calculator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  svpwm_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        out_hold = 1'b0;
      end
      w = no_gaps ? 0 : $urandom_range(0, 17);
      if (w > 0 && $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [15:0] vd, logic [15:0] vq, logic [15:0] bus,
                              logic [15:0] sn, logic [15:0] cs);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) w = 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_tdata <= {cs, sn, bus, vq, vd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_edge();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ang, mag;
    real th;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, zero bus, sector edges, all sectors, overmodulation
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_request(16'h7fff, 16'h7fff, 16'h0000, 16'h8000, 16'h8000);
    send_request(16'h8000, 16'h8000, 16'hffff, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff);
    send_request(16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_request(16'h1000, 16'h0000, 16'h4000, 16'h0000, 16'h7fff);
    send_request(16'h1000, 16'h0000, 16'h4000, 16'h7fff, 16'h0000);
    send_request(16'hf000, 16'h0000, 16'h4000, 16'h0000, 16'h7fff);
    send_request(16'hf000, 16'h0000, 16'h4000, 16'h7fff, 16'h0000);
    send_request(16'h7fff, 16'h7fff, 16'h0100, 16'h4000, 16'h6000);
    for (int k = 0; k < 12; k++) begin
      th = 3.14159265 * k / 6.0 + 0.01;
      send_request(16'h2000, 16'h0000, 16'h6000,
                   16'($rtoi(32767.0 * $sin(th))), 16'($rtoi(32767.0 * $cos(th))));
    end

    for (int n = 0; n < 1530; n++) begin
      if (n == 300) out_hold = 1'b1;
      if (n == 700) begin
        in_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      no_gaps = (n >= 1000 && n < 1150);
      if ($urandom_range(0, 4) == 0) begin
        send_request(rand_edge(), rand_edge(), rand_edge(), rand_edge(), rand_edge());
      end else begin
        th = ($urandom % 62832) / 10000.0;
        mag = 16'($urandom_range(0, 32767));
        ang = 16'($urandom_range(0, 32767));
        send_request(mag, ($urandom_range(0, 1) ? ang : -ang),
                     ($urandom_range(0, 20) == 0) ? 16'h0000 : 16'($urandom),
                     16'($rtoi(32767.0 * $sin(th))), 16'($rtoi(32767.0 * $cos(th))));
      end
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d requests, checked %0d results over %0d cycles",
             sent_count, result_count, cycle_count);
    $display("covered zero bus, field extremes, all six sectors and overmodulation");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending_count);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
